// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk with asynchronous reset arst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge outside reset
`define TSBB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication: when ante holds, cons holds in the same cycle
`define TSBB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: design/tsbb_pkg.sv
// ----------------------------------------------------------------------------
// tsbb_pkg
// types, widths and helpers shared by the bounding box unit
// ----------------------------------------------------------------------------
package tsbb_pkg;

	// port and register widths
	localparam int COORD_W = 32;
	localparam int SCL_W   = 16;
	localparam int SIZE_W  = 31;
	localparam int MODE_W  = 3;
	localparam int APB_AW  = 5;
	localparam int APB_DW  = 32;
	localparam int REG_IDX_W = 3;

	// internal arithmetic widths
	localparam int LOC_W   = 34;                // doubled local point
	localparam int SPRD_W  = LOC_W + SCL_W;     // point times scale
	localparam int SCD_SH  = 9;
	localparam int SCD_W   = SPRD_W - SCD_SH;   // scaled point, q16.16
	localparam int ROT_SH  = 14;
	localparam int RPRD_W  = SCD_W + SCL_W;     // scaled times cos or sin
	localparam int WSUM_W  = RPRD_W + 2;
	localparam int WLD_W   = WSUM_W - ROT_SH;   // world coordinate, unsaturated
	localparam int RAD_SH  = 8;
	localparam int RADP_W  = SIZE_W + SCL_W;
	localparam int RAD_W   = RADP_W - RAD_SH;   // circle radius, q16.16
	localparam int ACC_W   = WLD_W + 1;         // box accumulator

	localparam int NUM_CORNERS = 4;
	localparam int CRN_W = $clog2(NUM_CORNERS);

	localparam logic signed [SPRD_W-1:0] SCD_RND = SPRD_W'(1) << (SCD_SH - 1);
	localparam logic [RADP_W-1:0]        RAD_RND = RADP_W'(1) << (RAD_SH - 1);
	localparam logic [ROT_SH-1:0]        ROT_RND = ROT_SH'(1) << (ROT_SH - 1);

	// reset values of the registers
	localparam logic signed [SCL_W-1:0] SCALE_ONE = 16'sd256;
	localparam logic signed [SCL_W-1:0] COS_ONE   = 16'sd16384;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_POS_X   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_POS_Y   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SCALE_X = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SCALE_Y = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_COS_ROT = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SIN_ROT = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_OFF_X   = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_OFF_Y   = 3'd7;

	typedef enum logic [MODE_W-1:0] {
		MODE_POLY   = 3'd0,
		MODE_EDGE   = 3'd1,
		MODE_CIRCLE = 3'd2,
		MODE_BOX    = 3'd3,
		MODE_EMPTY  = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [SCL_W-1:0]   scale_x;
		logic signed [SCL_W-1:0]   scale_y;
		logic signed [SCL_W-1:0]   cos_rot;
		logic signed [SCL_W-1:0]   sin_rot;
		logic signed [COORD_W-1:0] off_x;
		logic signed [COORD_W-1:0] off_y;
	} cfg_t;

	typedef struct packed {
		logic             capture;    // take the word into the item registers
		logic             issue;      // start one point down the pipeline
		logic             use_ports;  // source is the input ports, not the item registers
		logic [CRN_W-1:0] corner;
		logic             first;      // first corner of the item
		logic             fin;        // last corner of the item
		logic             load_out;   // load the output register
	} dp_cmd_t;

	typedef struct packed {
		logic done;                   // accumulators hold the finished item
	} dp_sts_t;

	function automatic logic mode_is_point(input mode_t m);
		logic r;
		r = (m == MODE_POLY) || (m == MODE_EDGE);
		return r;
	endfunction

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-COORD_W:0] top;
		logic signed [COORD_W-1:0] r;
		top = v[ACC_W-1:COORD_W-1];
		if (top == '0 || top == '1) begin
			r = v[COORD_W-1:0];
		end else if (v[ACC_W-1]) begin
			r = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(COORD_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

// File: design/tsbb_regs.sv
// ----------------------------------------------------------------------------
// tsbb_regs
// apb register file holding position, scale, rotation and shape offset
// ----------------------------------------------------------------------------
module tsbb_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tsbb_pkg::APB_AW-1:0]   paddr,
	input  logic [tsbb_pkg::APB_DW-1:0]   pwdata,
	output logic [tsbb_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output tsbb_pkg::cfg_t                cfg
);
	import tsbb_pkg::*;

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;

	assign idx    = paddr[APB_AW-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_x   <= '0;
			cfg_q.pos_y   <= '0;
			cfg_q.scale_x <= SCALE_ONE;
			cfg_q.scale_y <= SCALE_ONE;
			cfg_q.cos_rot <= COS_ONE;
			cfg_q.sin_rot <= '0;
			cfg_q.off_x   <= '0;
			cfg_q.off_y   <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_POS_X:   cfg_q.pos_x   <= pwdata;
				REG_POS_Y:   cfg_q.pos_y   <= pwdata;
				REG_SCALE_X: cfg_q.scale_x <= pwdata[SCL_W-1:0];
				REG_SCALE_Y: cfg_q.scale_y <= pwdata[SCL_W-1:0];
				REG_COS_ROT: cfg_q.cos_rot <= pwdata[SCL_W-1:0];
				REG_SIN_ROT: cfg_q.sin_rot <= pwdata[SCL_W-1:0];
				REG_OFF_X:   cfg_q.off_x   <= pwdata;
				REG_OFF_Y:   cfg_q.off_y   <= pwdata;
				default: begin
				end
			endcase
		end
	end

	// narrow registers read back sign-extended
	always_comb begin
		case (idx)
			REG_POS_X:   prdata = cfg_q.pos_x;
			REG_POS_Y:   prdata = cfg_q.pos_y;
			REG_SCALE_X: prdata = APB_DW'(cfg_q.scale_x);
			REG_SCALE_Y: prdata = APB_DW'(cfg_q.scale_y);
			REG_COS_ROT: prdata = APB_DW'(cfg_q.cos_rot);
			REG_SIN_ROT: prdata = APB_DW'(cfg_q.sin_rot);
			REG_OFF_X:   prdata = cfg_q.off_x;
			REG_OFF_Y:   prdata = cfg_q.off_y;
			default:     prdata = '0;
		endcase
	end

endmodule

// File: design/tsbb_dp.sv
// ----------------------------------------------------------------------------
// tsbb_dp
// transform pipeline, box accumulators, running point box and output register
// ----------------------------------------------------------------------------
module tsbb_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tsbb_pkg::cfg_t                    cfg,
	input  tsbb_pkg::dp_cmd_t                 cmd,
	output tsbb_pkg::dp_sts_t                 sts,
	input  logic [tsbb_pkg::MODE_W-1:0]       mode,
	input  logic signed [tsbb_pkg::COORD_W-1:0] px,
	input  logic signed [tsbb_pkg::COORD_W-1:0] py,
	input  logic [tsbb_pkg::SIZE_W-1:0]       size_x,
	input  logic [tsbb_pkg::SIZE_W-1:0]       size_y,
	input  logic                              last,
	output logic signed [tsbb_pkg::COORD_W-1:0] min_x,
	output logic signed [tsbb_pkg::COORD_W-1:0] min_y,
	output logic signed [tsbb_pkg::COORD_W-1:0] max_x,
	output logic signed [tsbb_pkg::COORD_W-1:0] max_y
);
	import tsbb_pkg::*;

	// item registers, for corners after the first
	mode_t                     mode_q;
	logic signed [COORD_W-1:0] px_q, py_q;
	logic [SIZE_W-1:0]         szx_q, szy_q;
	logic                      last_q;

	// stage 1 sources
	mode_t                     src_mode;
	logic signed [COORD_W-1:0] src_px, src_py;
	logic [SIZE_W-1:0]         src_szx, src_szy;
	logic                      src_last;
	logic signed [LOC_W-2:0]   px_e, py_e, offx_e, offy_e;
	logic signed [LOC_W-2:0]   sum_x, sum_y;
	logic signed [LOC_W-1:0]   off2_x, off2_y, szx_l, szy_l;
	logic signed [LOC_W-1:0]   lx, ly;
	logic [SCL_W-1:0]          abs_x, abs_y;

	// pipeline
	logic                      v_s1, v_s2, v_s3, v_s4;
	logic                      first_s1, first_s2, first_s3, first_s4;
	logic                      fin_s1, fin_s2, fin_s3, fin_s4;
	logic                      last_s1, last_s2, last_s3, last_s4;
	mode_t                     mode_s1, mode_s2, mode_s3, mode_s4;
	logic signed [LOC_W-1:0]   lx_s1, ly_s1;
	logic [SCL_W-1:0]          maxabs_s1;
	logic [SIZE_W-1:0]         szx_s1;
	logic signed [SPRD_W-1:0]  prod_x, prod_y;
	logic [RADP_W-1:0]         rad_p;
	logic signed [SCD_W-1:0]   sx_s2, sy_s2;
	logic [RAD_W-1:0]          r_s2, r_s3, r_s4;
	logic signed [RPRD_W-1:0]  xc_s3, ys_s3, xs_s3, yc_s3;
	logic signed [WSUM_W-1:0]  wx_sum, wy_sum;
	logic signed [WLD_W-1:0]   wx_s4, wy_s4;

	// accumulate
	logic signed [ACC_W-1:0]   wx_a, wy_a, r_a;
	logic signed [COORD_W-1:0] sat_x, sat_y;
	logic signed [COORD_W-1:0] run_min_x_q, run_min_y_q, run_max_x_q, run_max_y_q;
	logic signed [COORD_W-1:0] run_min_x_n, run_min_y_n, run_max_x_n, run_max_y_n;
	logic                      first_point_q;
	logic signed [ACC_W-1:0]   bmin_x_q, bmin_y_q, bmax_x_q, bmax_y_q;
	logic signed [ACC_W-1:0]   bmin_x_n, bmin_y_n, bmax_x_n, bmax_y_n;
	logic                      done_q;

	logic signed [COORD_W-1:0] min_x_q, min_y_q, max_x_q, max_y_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode_t'(mode);
			px_q   <= px;
			py_q   <= py;
			szx_q  <= size_x;
			szy_q  <= size_y;
			last_q <= last;
		end
	end

	// stage 1: local point, doubled
	always_comb begin
		src_mode = cmd.use_ports ? mode_t'(mode) : mode_q;
		src_px   = cmd.use_ports ? px     : px_q;
		src_py   = cmd.use_ports ? py     : py_q;
		src_szx  = cmd.use_ports ? size_x : szx_q;
		src_szy  = cmd.use_ports ? size_y : szy_q;
		src_last = cmd.use_ports ? last   : last_q;

		px_e   = (LOC_W-1)'(src_px);
		py_e   = (LOC_W-1)'(src_py);
		offx_e = (LOC_W-1)'(cfg.off_x);
		offy_e = (LOC_W-1)'(cfg.off_y);
		sum_x  = px_e + offx_e;
		sum_y  = py_e + offy_e;
		off2_x = {offx_e, 1'b0};
		off2_y = {offy_e, 1'b0};
		szx_l  = LOC_W'(src_szx);
		szy_l  = LOC_W'(src_szy);

		case (src_mode)
			MODE_POLY: begin
				lx = {sum_x, 1'b0};
				ly = {sum_y, 1'b0};
			end
			MODE_EDGE: begin
				lx = {px_e, 1'b0};
				ly = {py_e, 1'b0};
			end
			MODE_CIRCLE: begin
				lx = off2_x;
				ly = off2_y;
			end
			MODE_BOX: begin
				// corners 1 and 2 on the plus side of x, 2 and 3 on the plus side of y
				lx = (cmd.corner[0] ^ cmd.corner[1]) ? off2_x + szx_l : off2_x - szx_l;
				ly = cmd.corner[1] ? off2_y + szy_l : off2_y - szy_l;
			end
			default: begin
				lx = '0;
				ly = '0;
			end
		endcase

		abs_x = cfg.scale_x[SCL_W-1] ? SCL_W'(-cfg.scale_x) : SCL_W'(cfg.scale_x);
		abs_y = cfg.scale_y[SCL_W-1] ? SCL_W'(-cfg.scale_y) : SCL_W'(cfg.scale_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		lx_s1     <= lx;
		ly_s1     <= ly;
		maxabs_s1 <= (abs_x > abs_y) ? abs_x : abs_y;
		szx_s1    <= src_szx;
		mode_s1   <= src_mode;
		first_s1  <= cmd.first;
		fin_s1    <= cmd.fin;
		last_s1   <= src_last;
	end

	// stage 2: scale, rounded to q16.16
	assign prod_x = lx_s1 * cfg.scale_x;
	assign prod_y = ly_s1 * cfg.scale_y;
	assign rad_p  = szx_s1 * maxabs_s1 + RAD_RND;

	always_ff @(posedge clk) begin
		sx_s2    <= SCD_W'((prod_x + SCD_RND) >>> SCD_SH);
		sy_s2    <= SCD_W'((prod_y + SCD_RND) >>> SCD_SH);
		r_s2     <= rad_p[RADP_W-1:RAD_SH];
		mode_s2  <= mode_s1;
		first_s2 <= first_s1;
		fin_s2   <= fin_s1;
		last_s2  <= last_s1;
	end

	// stage 3: rotation products
	always_ff @(posedge clk) begin
		xc_s3    <= sx_s2 * cfg.cos_rot;
		ys_s3    <= sy_s2 * cfg.sin_rot;
		xs_s3    <= sx_s2 * cfg.sin_rot;
		yc_s3    <= sy_s2 * cfg.cos_rot;
		r_s3     <= r_s2;
		mode_s3  <= mode_s2;
		first_s3 <= first_s2;
		fin_s3   <= fin_s2;
		last_s3  <= last_s2;
	end

	// stage 4: sum, round and translate in one add; position carries the rounding half
	assign wx_sum = WSUM_W'(xc_s3) - WSUM_W'(ys_s3) + WSUM_W'($signed({cfg.pos_x, ROT_RND}));
	assign wy_sum = WSUM_W'(xs_s3) + WSUM_W'(yc_s3) + WSUM_W'($signed({cfg.pos_y, ROT_RND}));

	always_ff @(posedge clk) begin
		wx_s4    <= wx_sum[WSUM_W-1:ROT_SH];
		wy_s4    <= wy_sum[WSUM_W-1:ROT_SH];
		r_s4     <= r_s3;
		mode_s4  <= mode_s3;
		first_s4 <= first_s3;
		fin_s4   <= fin_s3;
		last_s4  <= last_s3;
	end

	// accumulate
	always_comb begin
		wx_a  = ACC_W'(wx_s4);
		wy_a  = ACC_W'(wy_s4);
		r_a   = ACC_W'($signed({1'b0, r_s4}));
		sat_x = sat_coord(wx_a);
		sat_y = sat_coord(wy_a);

		run_min_x_n = (first_point_q || sat_x < run_min_x_q) ? sat_x : run_min_x_q;
		run_max_x_n = (first_point_q || sat_x > run_max_x_q) ? sat_x : run_max_x_q;
		run_min_y_n = (first_point_q || sat_y < run_min_y_q) ? sat_y : run_min_y_q;
		run_max_y_n = (first_point_q || sat_y > run_max_y_q) ? sat_y : run_max_y_q;

		case (mode_s4)
			MODE_POLY, MODE_EDGE: begin
				bmin_x_n = ACC_W'(run_min_x_n);
				bmin_y_n = ACC_W'(run_min_y_n);
				bmax_x_n = ACC_W'(run_max_x_n);
				bmax_y_n = ACC_W'(run_max_y_n);
			end
			MODE_CIRCLE: begin
				bmin_x_n = wx_a - r_a;
				bmin_y_n = wy_a - r_a;
				bmax_x_n = wx_a + r_a;
				bmax_y_n = wy_a + r_a;
			end
			MODE_BOX: begin
				bmin_x_n = (first_s4 || wx_a < bmin_x_q) ? wx_a : bmin_x_q;
				bmin_y_n = (first_s4 || wy_a < bmin_y_q) ? wy_a : bmin_y_q;
				bmax_x_n = (first_s4 || wx_a > bmax_x_q) ? wx_a : bmax_x_q;
				bmax_y_n = (first_s4 || wy_a > bmax_y_q) ? wy_a : bmax_y_q;
			end
			default: begin
				bmin_x_n = ACC_W'(cfg.pos_x);
				bmin_y_n = ACC_W'(cfg.pos_y);
				bmax_x_n = ACC_W'(cfg.pos_x);
				bmax_y_n = ACC_W'(cfg.pos_y);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_x_q   <= '0;
			run_min_y_q   <= '0;
			run_max_x_q   <= '0;
			run_max_y_q   <= '0;
			first_point_q <= 1'b1;
			done_q        <= 1'b0;
		end else begin
			done_q <= v_s4 & fin_s4;
			if (v_s4 && mode_is_point(mode_s4)) begin
				run_min_x_q   <= run_min_x_n;
				run_min_y_q   <= run_min_y_n;
				run_max_x_q   <= run_max_x_n;
				run_max_y_q   <= run_max_y_n;
				first_point_q <= last_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4) begin
			bmin_x_q <= bmin_x_n;
			bmin_y_q <= bmin_y_n;
			bmax_x_q <= bmax_x_n;
			bmax_y_q <= bmax_y_n;
		end
	end

	// output register, saturated here; point values are also saturated per point
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			min_x_q <= sat_coord(bmin_x_q);
			min_y_q <= sat_coord(bmin_y_q);
			max_x_q <= sat_coord(bmax_x_q);
			max_y_q <= sat_coord(bmax_y_q);
		end
	end

	assign sts.done = done_q;
	assign min_x    = min_x_q;
	assign min_y    = min_y_q;
	assign max_x    = max_x_q;
	assign max_y    = max_y_q;

endmodule

// File: design/tsbb_ctrl.sv
// ----------------------------------------------------------------------------
// tsbb_ctrl
// sequencer: accepts a word, issues its corners, waits for the pipeline and
// hands the result to the output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsbb_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tsbb_pkg::MODE_W-1:0] mode,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output tsbb_pkg::dp_cmd_t           cmd,
	input  tsbb_pkg::dp_sts_t           sts
);
	import tsbb_pkg::*;

	state_t           state_q, state_n;
	logic [CRN_W-1:0] corner_q, corner_n;
	logic             emit_q, emit_n;
	logic             out_valid_q;
	logic             out_free;
	mode_t            in_mode;

	assign in_mode  = mode_t'(mode);
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			corner_q    <= '0;
			emit_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			corner_q    <= corner_n;
			emit_q      <= emit_n;
			out_valid_q <= cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_q);
		end
	end

	always_comb begin
		state_n  = state_q;
		corner_n = corner_q;
		emit_n   = emit_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				// ready is always high here, so valid alone means the word is taken
				in_ready      = 1'b1;
				cmd.use_ports = 1'b1;
				cmd.first     = 1'b1;
				cmd.fin       = (in_mode != MODE_BOX);
				if (in_valid) begin
					cmd.capture = 1'b1;
					cmd.issue   = 1'b1;
					emit_n      = !mode_is_point(in_mode) || last;
					corner_n    = CRN_W'(1);
					state_n     = (in_mode == MODE_BOX) ? ST_ISSUE : ST_WAIT;
				end
			end
			ST_ISSUE: begin
				cmd.issue  = 1'b1;
				cmd.corner = corner_q;
				cmd.fin    = (corner_q == CRN_W'(NUM_CORNERS - 1));
				corner_n   = corner_q + CRN_W'(1);
				if (cmd.fin) begin
					state_n = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (sts.done) begin
					if (!emit_q) begin
						state_n = ST_IDLE;
					end else if (out_free) begin
						cmd.load_out = 1'b1;
						state_n      = ST_IDLE;
					end else begin
						state_n = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	// a waiting result is never overwritten
	`TSBB_ASSERT_IMP(a_no_overwrite, cmd.load_out, out_free, "output word overwritten")
	// the pipeline finishes only while the sequencer waits for it
	`TSBB_ASSERT_IMP(a_done_in_wait, sts.done, state_q == ST_WAIT, "item finished outside wait")
	// corner zero always comes straight from the ports
	`TSBB_ASSERT_IMP(a_issue_corner, state_q == ST_ISSUE, corner_q != '0, "corner zero reissued")
	// a result is loaded only for an item that has one
	`TSBB_ASSERT_IMP(a_load_emit, cmd.load_out, emit_q, "result loaded for a point without last")

endmodule

// File: design/transformed_shape_bounding_box_unit.sv
// ----------------------------------------------------------------------------
// transformed_shape_bounding_box_unit
// world-space bounding box of one collider shape under scale, rotation and
// translation, with a running box over polygon and edge point lists
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                       payload
// apb       in/out     psel, penable, pwrite, pready   paddr, pwdata, prdata
// in        in         in_valid, in_ready              mode, px, py, size_x, size_y, last
// out       out        out_valid, out_ready            min_x, min_y, max_x, max_y
//
// the output register loads once the last corner of the item has left five register
// stages (local point, scale, rotation products, translate, accumulate); they share one
// path that takes one corner per cycle, and a box feeds it four corners
// one word in flight; in_ready returns once the result has loaded, or once a point without last is done
// a result waits in the output register while out_ready is low and the next word is
// taken meanwhile; a second result then holds in_ready low until the first leaves
// reset clears the sequencer and running box and sets identity transform at the origin
//
module transformed_shape_bounding_box_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tsbb_pkg::APB_AW-1:0]         paddr,
	input  logic [tsbb_pkg::APB_DW-1:0]         pwdata,
	output logic [tsbb_pkg::APB_DW-1:0]         prdata,
	output logic                                pready,
	// input words
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [tsbb_pkg::MODE_W-1:0]         mode,
	input  logic signed [tsbb_pkg::COORD_W-1:0] px,
	input  logic signed [tsbb_pkg::COORD_W-1:0] py,
	input  logic [tsbb_pkg::SIZE_W-1:0]         size_x,
	input  logic [tsbb_pkg::SIZE_W-1:0]         size_y,
	input  logic                                last,
	// result words
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [tsbb_pkg::COORD_W-1:0] min_x,
	output logic signed [tsbb_pkg::COORD_W-1:0] min_y,
	output logic signed [tsbb_pkg::COORD_W-1:0] max_x,
	output logic signed [tsbb_pkg::COORD_W-1:0] max_y
);
	import tsbb_pkg::*;

	cfg_t    cfg;   // register contents; the user keeps them stable while a word is in flight, unenforced
	dp_cmd_t cmd;   // sequencer to datapath
	dp_sts_t sts;   // datapath to sequencer

	// register file
	tsbb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: decides corners and when the output register loads
	tsbb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// transform pipeline and accumulators
	tsbb_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts),
		.mode   (mode),
		.px     (px),
		.py     (py),
		.size_x (size_x),
		.size_y (size_y),
		.last   (last),
		.min_x  (min_x),
		.min_y  (min_y),
		.max_x  (max_x),
		.max_y  (max_y)
	);

endmodule

// File: dv/transformed_shape_bounding_box_unit_tb.sv
// ----------------------------------------------------------------------------
// transformed_shape_bounding_box_unit_tb
// self-checking bench for the shape bounding box unit: words go in through a
// queue-fed driver, every box that comes out is checked against an in-bench
// fixed-point predictor, and the registers are reloaded between traffic phases
// ----------------------------------------------------------------------------
module transformed_shape_bounding_box_unit_tb;
	import tsbb_pkg::*;

	// bench timing
	localparam int CLK_PERIOD     = 4;
	localparam int RESET_CYCLES   = 11;
	localparam int QUIET_CYCLES   = 24;      // long enough for a box to clear the pipeline
	localparam int TIMEOUT_CYCLES = 400_000;

	// traffic shape
	localparam int NUM_PHASES       = 10;
	localparam int RANDOM_PER_PHASE = 150;
	localparam int HOLD_CYCLES      = 240;
	localparam int HOLD_FIRST       = 300;
	localparam int HOLD_EVERY       = 600;

	// value extremes
	localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic [SIZE_W-1:0]         S_MAX = '1;
	localparam logic signed [SCL_W-1:0]   SCALE_MAX = {1'b0, {(SCL_W-1){1'b1}}};
	localparam logic signed [SCL_W-1:0]   SCALE_MIN = {1'b1, {(SCL_W-1){1'b0}}};
	localparam longint COORD_HI = C_MAX;
	localparam longint COORD_LO = C_MIN;
	localparam longint ROT_ONE  = COS_ONE;
	localparam int     MODE_TOP = (1 << MODE_W) - 1;
	localparam int     NEAR_SPAN = 32'h0040_0000;

	typedef struct packed {
		logic [MODE_W-1:0]         mode;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic [SIZE_W-1:0]         size_x;
		logic [SIZE_W-1:0]         size_y;
		logic                      last;
	} shape_word_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] max_y;
	} aabb_t;

	// ports, the bench-driven ones known from time zero
	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [APB_AW-1:0]         paddr = '0;
	logic [APB_DW-1:0]         pwdata = '0;
	logic [APB_DW-1:0]         prdata;
	logic                      pready;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [MODE_W-1:0]         mode = '0;
	logic signed [COORD_W-1:0] px = '0;
	logic signed [COORD_W-1:0] py = '0;
	logic [SIZE_W-1:0]         size_x = '0;
	logic [SIZE_W-1:0]         size_y = '0;
	logic                      last = 1'b0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [COORD_W-1:0] min_x;
	logic signed [COORD_W-1:0] min_y;
	logic signed [COORD_W-1:0] max_x;
	logic signed [COORD_W-1:0] max_y;

	// words still to be offered, and boxes the predictor has promised
	shape_word_t pending_words[$];
	aabb_t       expected_boxes[$];
	shape_word_t on_port;

	// shadow of the register file, sign-extended, indexed by register number
	longint reg_val [8];
	longint setup_val [8];

	// running box of the point list that the predictor tracks
	longint run_lo_x = 0, run_lo_y = 0, run_hi_x = 0, run_hi_y = 0;
	bit     list_open = 1'b0;

	// idling control and bookkeeping
	bit src_lazy = 1'b0;
	bit snk_lazy = 1'b0;
	int src_gap;
	int sink_pause;
	int hold_left;
	int next_hold_at;
	int words_in = 0;
	int boxes_checked = 0;
	int holds_seen = 0;
	int setups_loaded = 0;
	int mismatches = 0;

	transformed_shape_bounding_box_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.px       (px),
		.py       (py),
		.size_x   (size_x),
		.size_y   (size_y),
		.last     (last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.min_x    (min_x),
		.min_y    (min_y),
		.max_x    (max_x),
		.max_y    (max_y)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	// round half towards plus infinity, then drop k fraction bits
	function automatic longint round_q(input longint v, input int k);
		return (v + (64'sd1 <<< (k - 1))) >>> k;
	endfunction

	function automatic logic signed [COORD_W-1:0] clamp_q(input longint v);
		if (v > COORD_HI)
			return C_MAX;
		if (v < COORD_LO)
			return C_MIN;
		return v[COORD_W-1:0];
	endfunction

	function automatic aabb_t make_box(input longint lx, ly, hx, hy);
		aabb_t b;
		b.min_x = clamp_q(lx);
		b.min_y = clamp_q(ly);
		b.max_x = clamp_q(hx);
		b.max_y = clamp_q(hy);
		return b;
	endfunction

	// doubled local point (q16.17) to unsaturated world q16.16:
	// scale per axis, rotate, translate
	function automatic void world_of(input longint lx2, ly2, output longint wx, wy);
		longint sx, sy, c, s;
		c  = reg_val[REG_COS_ROT];
		s  = reg_val[REG_SIN_ROT];
		sx = round_q(lx2 * reg_val[REG_SCALE_X], SCD_SH);
		sy = round_q(ly2 * reg_val[REG_SCALE_Y], SCD_SH);
		wx = reg_val[REG_POS_X] + round_q(sx * c - sy * s, ROT_SH);
		wy = reg_val[REG_POS_Y] + round_q(sx * s + sy * c, ROT_SH);
	endfunction

	// one word in; returns 1 and the box when the word produces a result
	function automatic bit step_shape(input shape_word_t w, output aabb_t box);
		longint lx, ly, wx, wy, szx, szy, rad, ax, ay, dx, dy;
		longint lo_x, lo_y, hi_x, hi_y, off_x2, off_y2;
		int k;
		box    = '0;
		szx    = w.size_x;
		szy    = w.size_y;
		off_x2 = 2 * reg_val[REG_OFF_X];
		off_y2 = 2 * reg_val[REG_OFF_Y];
		case (w.mode)
			MODE_POLY, MODE_EDGE: begin
				lx = $signed(w.px);
				ly = $signed(w.py);
				// only polygon points sit at the shape offset
				if (w.mode == MODE_POLY) begin
					lx = lx + reg_val[REG_OFF_X];
					ly = ly + reg_val[REG_OFF_Y];
				end
				world_of(2 * lx, 2 * ly, wx, wy);
				wx = clamp_q(wx);
				wy = clamp_q(wy);
				if (!list_open) begin
					run_lo_x = wx;
					run_hi_x = wx;
					run_lo_y = wy;
					run_hi_y = wy;
				end else begin
					if (wx < run_lo_x) run_lo_x = wx;
					if (wx > run_hi_x) run_hi_x = wx;
					if (wy < run_lo_y) run_lo_y = wy;
					if (wy > run_hi_y) run_hi_y = wy;
				end
				list_open = !w.last;
				if (!w.last)
					return 1'b0;
				box = make_box(run_lo_x, run_lo_y, run_hi_x, run_hi_y);
				return 1'b1;
			end
			MODE_CIRCLE: begin
				ax  = reg_val[REG_SCALE_X] < 0 ? -reg_val[REG_SCALE_X] : reg_val[REG_SCALE_X];
				ay  = reg_val[REG_SCALE_Y] < 0 ? -reg_val[REG_SCALE_Y] : reg_val[REG_SCALE_Y];
				rad = round_q(szx * (ax > ay ? ax : ay), RAD_SH);
				world_of(off_x2, off_y2, wx, wy);
				box = make_box(wx - rad, wy - rad, wx + rad, wy + rad);
				return 1'b1;
			end
			MODE_BOX: begin
				lo_x = 0; lo_y = 0; hi_x = 0; hi_y = 0;
				for (k = 0; k < NUM_CORNERS; k++) begin
					dx = (k == 1 || k == 2) ? szx : -szx;
					dy = (k >= 2) ? szy : -szy;
					world_of(off_x2 + dx, off_y2 + dy, wx, wy);
					if (k == 0 || wx < lo_x) lo_x = wx;
					if (k == 0 || wx > hi_x) hi_x = wx;
					if (k == 0 || wy < lo_y) lo_y = wy;
					if (k == 0 || wy > hi_y) hi_y = wy;
				end
				box = make_box(lo_x, lo_y, hi_x, hi_y);
				return 1'b1;
			end
			// empty and the spare codes give the position alone
			default: begin
				box = make_box(reg_val[REG_POS_X], reg_val[REG_POS_Y],
					reg_val[REG_POS_X], reg_val[REG_POS_Y]);
				return 1'b1;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// mismatch reporting
	// ------------------------------------------------------------------------
	task automatic flag_error(input string what);
		mismatches++;
		$display("ERROR at %0t: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic signed [COORD_W-1:0] got, want);
		if (got !== want)
			flag_error($sformatf("box %0d %s got %0d expected %0d",
				boxes_checked, name, got, want));
	endtask

	// ------------------------------------------------------------------------
	// word driver: pops the queue, holds valid until taken, predicts on take
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : word_driver
		shape_word_t w;
		aabb_t       box;
		if (!arst_n) begin
			in_valid <= 1'b0;
			src_gap  <= 0;
		end else begin
			// the word on the port is taken at this edge
			if (in_valid && in_ready) begin
				if (step_shape(on_port, box))
					expected_boxes.insert(expected_boxes.size(), box);
				words_in <= words_in + 1;
			end
			// port is free after this edge: idle out the gap or offer the next word
			if (!in_valid || in_ready) begin
				if (src_gap > 0) begin
					src_gap  <= src_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					w = pending_words.pop_front();
					mode     <= w.mode;
					px       <= w.px;
					py       <= w.py;
					size_x   <= w.size_x;
					size_y   <= w.size_y;
					last     <= w.last;
					on_port  <= w;
					in_valid <= 1'b1;
					src_gap  <= src_lazy ? $urandom_range(0, 7) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// result monitor: checks each taken box, then draws a pause before ready
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : box_monitor
		aabb_t want;
		int    pause;
		if (!arst_n) begin
			out_ready  <= 1'b0;
			sink_pause <= 0;
		end else begin
			pause = sink_pause;
			if (out_valid && out_ready) begin
				if (expected_boxes.size() == 0) begin
					flag_error($sformatf("box (%0d,%0d)-(%0d,%0d) with none expected",
						min_x, min_y, max_x, max_y));
				end else begin
					want = expected_boxes.pop_front();
					check_field("min_x", min_x, want.min_x);
					check_field("min_y", min_y, want.min_y);
					check_field("max_x", max_x, want.max_x);
					check_field("max_y", max_y, want.max_y);
					boxes_checked <= boxes_checked + 1;
				end
				pause = snk_lazy ? $urandom_range(0, 7) : 0;
			end else if (pause > 0) begin
				pause = pause - 1;
			end
			sink_pause <= pause;
			out_ready  <= (pause == 0) && (hold_left == 0);
		end
	end

	// ------------------------------------------------------------------------
	// long back-pressure: with plenty of words still queued, the sink stops
	// for a stretch so the output register fills and in_ready drops
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left    <= 0;
			next_hold_at <= HOLD_FIRST;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (words_in >= next_hold_at && pending_words.size() > 8) begin
			hold_left    <= HOLD_CYCLES;
			next_hold_at <= next_hold_at + HOLD_EVERY;
			holds_seen   <= holds_seen + 1;
		end
	end

	// ------------------------------------------------------------------------
	// register writes: setup then access cycle, only while the unit is idle
	// ------------------------------------------------------------------------
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input longint value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'({idx, 2'b00});
		pwdata  <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx inside {REG_SCALE_X, REG_SCALE_Y, REG_COS_ROT, REG_SIN_ROT})
			reg_val[idx] = $signed(value[SCL_W-1:0]);
		else
			reg_val[idx] = $signed(value[COORD_W-1:0]);
	endtask

	task automatic apply_setup();
		int i;
		for (i = 0; i < 8; i++)
			write_reg(REG_IDX_W'(i), setup_val[i]);
		setups_loaded++;
	endtask

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	function automatic logic [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return C_MAX;
			1: return C_MIN;
			2: return COORD_W'($urandom_range(0, 2)) - 1;
			3, 4, 5: return $urandom;
			default: return COORD_W'($urandom_range(0, NEAR_SPAN)) - COORD_W'(NEAR_SPAN / 2);
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] rand_size();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return S_MAX;
			2, 3: return SIZE_W'($urandom);
			default: return SIZE_W'($urandom_range(0, NEAR_SPAN));
		endcase
	endfunction

	function automatic longint rand_scale();
		case ($urandom_range(0, 5))
			0: return SCALE_ONE;
			1: return -SCALE_ONE;
			2: return 0;
			3: return $signed(SCL_W'($urandom));
			default: return longint'($urandom_range(0, 1024)) - 512;
		endcase
	endfunction

	// circle, box, empty or one of the spare codes, boxes and spare codes most often
	function automatic logic [MODE_W-1:0] rand_whole_mode();
		case ($urandom_range(0, 5))
			0: return MODE_CIRCLE;
			1, 2: return MODE_BOX;
			3: return MODE_EMPTY;
			default: return MODE_W'($urandom_range(int'(MODE_EMPTY) + 1, MODE_TOP));
		endcase
	endfunction

	task automatic push_word(input logic [MODE_W-1:0] m, input logic [COORD_W-1:0] x, y,
			input logic [SIZE_W-1:0] sx, sy, input logic fin);
		shape_word_t w;
		w.mode   = m;
		w.px     = x;
		w.py     = y;
		w.size_x = sx;
		w.size_y = sy;
		w.last   = fin;
		pending_words.insert(pending_words.size(), w);
	endtask

	// hand-picked words: extremes, every mode, shapes inside an open list
	task automatic queue_directed();
		push_word(MODE_POLY, 0, 0, 0, 0, 1'b1);
		push_word(MODE_POLY, C_MAX, C_MIN, 0, 0, 1'b0);
		push_word(MODE_POLY, C_MIN, C_MAX, 0, 0, 1'b0);
		push_word(MODE_EDGE, -1, 1, 0, 0, 1'b0);
		push_word(MODE_POLY, 32'sh0001_0000, -32'sh0001_0000, 0, 0, 1'b1);
		push_word(MODE_EDGE, C_MAX, C_MAX, 0, 0, 1'b1);
		push_word(MODE_CIRCLE, 0, 0, S_MAX, S_MAX, 1'b0);
		push_word(MODE_CIRCLE, C_MAX, C_MIN, 0, 0, 1'b1);
		push_word(MODE_BOX, 0, 0, S_MAX, S_MAX, 1'b0);
		push_word(MODE_BOX, 0, 0, 0, 0, 1'b0);
		push_word(MODE_BOX, 0, 0, 31'h0003_0000, 31'd1, 1'b1);
		push_word(MODE_EMPTY, C_MIN, C_MIN, S_MAX, 0, 1'b0);
		push_word(MODE_W'(int'(MODE_EMPTY) + 1), 0, 0, 0, 0, 1'b0);
		push_word(MODE_W'(int'(MODE_EMPTY) + 2), -1, -1, S_MAX, S_MAX, 1'b1);
		push_word(MODE_W'(MODE_TOP), 0, 0, 0, 0, 1'b0);
		// whole shapes arriving in the middle of a point list
		push_word(MODE_EDGE, C_MIN, C_MIN, 0, 0, 1'b0);
		push_word(MODE_CIRCLE, 0, 0, 31'h0001_0000, 0, 1'b0);
		push_word(MODE_BOX, 0, 0, 31'h0002_0000, 31'h0000_8000, 1'b0);
		push_word(MODE_EMPTY, 0, 0, 0, 0, 1'b1);
		push_word(MODE_EDGE, 2, -2, 0, 0, 1'b1);
		// ignored fields set, single-point list
		push_word(MODE_POLY, -1, -1, S_MAX, S_MAX, 1'b1);
	endtask

	// mostly well-formed point lists, some loose shapes, a little noise
	task automatic queue_random_words(input int n);
		int made, len, k, pick;
		logic [MODE_W-1:0] list_mode, m;
		made = 0;
		while (made < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
				list_mode = $urandom_range(0, 1) ? MODE_EDGE : MODE_POLY;
				for (k = 0; k < len; k++) begin
					m = list_mode;
					// now and then the other point kind joins the same list
					if ($urandom_range(0, 7) == 0)
						m = (list_mode == MODE_POLY) ? MODE_EDGE : MODE_POLY;
					if ($urandom_range(0, 11) == 0) begin
						push_word(rand_whole_mode(), rand_coord(), rand_coord(),
							rand_size(), rand_size(), 1'($urandom_range(0, 1)));
						made++;
					end
					push_word(m, rand_coord(), rand_coord(), rand_size(), rand_size(),
						k == len - 1);
					made++;
				end
			end else if (pick < 92) begin
				push_word(rand_whole_mode(), rand_coord(), rand_coord(),
					rand_size(), rand_size(), 1'($urandom_range(0, 1)));
				made++;
			end else begin
				push_word(MODE_W'($urandom_range(0, MODE_TOP)), $urandom, $urandom,
					SIZE_W'($urandom), SIZE_W'($urandom), 1'($urandom_range(0, 1)));
				made++;
			end
		end
	endtask

	// idle means: nothing queued, nothing offered, no box outstanding, and
	// time for a trailing point with no result to leave the pipeline
	task automatic wait_quiet();
		while (pending_words.size() != 0 || in_valid || expected_boxes.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// run plan
	// ------------------------------------------------------------------------
	initial begin : run_plan
		int ph;
		reg_val[REG_POS_X]   = 0;
		reg_val[REG_POS_Y]   = 0;
		reg_val[REG_SCALE_X] = SCALE_ONE;
		reg_val[REG_SCALE_Y] = SCALE_ONE;
		reg_val[REG_COS_ROT] = COS_ONE;
		reg_val[REG_SIN_ROT] = 0;
		reg_val[REG_OFF_X]   = 0;
		reg_val[REG_OFF_Y]   = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (QUIET_CYCLES) @(posedge clk);
		@(negedge clk);

		// reset values: identity transform at the origin
		queue_directed();
		wait_quiet();

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			// some phases run flat out on the source side or on the sink side
			src_lazy = (ph % 3) != 1;
			snk_lazy = (ph % 4) != 2;
			if (ph == 0) begin
				setup_val[REG_POS_X]   = C_MAX;
				setup_val[REG_POS_Y]   = C_MAX;
				setup_val[REG_SCALE_X] = SCALE_MAX;
				setup_val[REG_SCALE_Y] = SCALE_MAX;
				setup_val[REG_COS_ROT] = ROT_ONE;
				setup_val[REG_SIN_ROT] = ROT_ONE;
				setup_val[REG_OFF_X]   = C_MAX;
				setup_val[REG_OFF_Y]   = C_MAX;
			end else if (ph == 1) begin
				setup_val[REG_POS_X]   = C_MIN;
				setup_val[REG_POS_Y]   = C_MIN;
				setup_val[REG_SCALE_X] = SCALE_MIN;
				setup_val[REG_SCALE_Y] = SCALE_MIN;
				setup_val[REG_COS_ROT] = -ROT_ONE;
				setup_val[REG_SIN_ROT] = -ROT_ONE;
				setup_val[REG_OFF_X]   = C_MIN;
				setup_val[REG_OFF_Y]   = C_MIN;
			end else begin
				setup_val[REG_POS_X]   = $signed(rand_coord());
				setup_val[REG_POS_Y]   = $signed(rand_coord());
				setup_val[REG_SCALE_X] = rand_scale();
				setup_val[REG_SCALE_Y] = rand_scale();
				setup_val[REG_COS_ROT] = longint'($urandom_range(0, 2 * ROT_ONE)) - ROT_ONE;
				setup_val[REG_SIN_ROT] = longint'($urandom_range(0, 2 * ROT_ONE)) - ROT_ONE;
				setup_val[REG_OFF_X]   = $signed(rand_coord());
				setup_val[REG_OFF_Y]   = $signed(rand_coord());
			end
			apply_setup();
			if (ph == 0)
				queue_directed();
			queue_random_words(RANDOM_PER_PHASE);
			wait_quiet();
		end

		$display("run covered %0d words and %0d checked boxes over %0d register setups",
			words_in, boxes_checked, setups_loaded + 1);
		$display("output held off %0d times for %0d cycles; %0d mismatches",
			holds_seen, HOLD_CYCLES, mismatches);
		if (mismatches == 0) begin
			$display("transformed_shape_bounding_box_unit verification clean");
		end else begin
			$display("transformed_shape_bounding_box_unit verification failed");
		end
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("timeout: %0d words queued, %0d boxes outstanding",
			pending_words.size(), expected_boxes.size());
		$display("transformed_shape_bounding_box_unit verification failed");
		$finish;
	end

endmodule
